### hw/rtl/pafd_pkg.sv
// Shared types, codes and small constant-divisor helpers for the packed
// ASCII field decoder. No dependencies.
`timescale 1ns / 1ps

package pafd_pkg;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned ValueWidth = 31;
    localparam logic [ValueWidth-1:0] ValueMax = {ValueWidth{1'b1}};

    // character codes
    localparam logic [7:0] ChBang    = 8'd33;   // '!'
    localparam logic [7:0] ChContHi  = 8'd74;   // 'J'
    localparam logic [7:0] ChFinLo   = 8'd75;   // 'K'
    localparam logic [7:0] ChLetHi   = 8'd116;  // 't'
    localparam logic [7:0] ChModeU   = 8'd117;  // 'u'
    localparam logic [7:0] ChModeY   = 8'd121;  // 'y'
    localparam logic [7:0] ChZero    = 8'd122;  // 'z'
    localparam logic [7:0] ChEnd     = 8'd125;  // '}'
    localparam logic [7:0] ChSpace   = 8'd32;
    localparam logic [7:0] ChTab     = 8'd9;
    localparam logic [7:0] ChCr      = 8'd13;

    localparam logic [7:0] FollowerStep = 8'd84;

    typedef enum logic [2:0] {
        KIND_VALUE   = 3'd0,
        KIND_RUN     = 3'd1,
        KIND_END     = 3'd2,
        KIND_BAD_LET = 3'd3,
        KIND_BAD_INT = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_INT    = 4'b0010,
        PH_RUN    = 4'b0100,
        PH_FOLLOW = 4'b1000
    } t_phase;

    typedef enum logic [4:0] {
        MODE_U = 5'b00001,
        MODE_V = 5'b00010,
        MODE_W = 5'b00100,
        MODE_X = 5'b01000,
        MODE_Y = 5'b10000
    } t_mode;

    // results caused by one input character
    typedef struct packed {
        logic [2:0]                                cnt;
        logic [MaxResults-1:0][2:0]                kind;
        logic [MaxResults-1:0][ValueWidth-1:0]     value;
    } t_bundle;

    // floor(x/3) for x < 128: x*43 >> 7
    function automatic logic [5:0] f_div3(input logic [6:0] x);
        logic [12:0] p;
        p = {6'd0, x} * 13'd43;
        return p[12:7];
    endfunction

    function automatic logic [1:0] f_mod3(input logic [6:0] x);
        logic [6:0] q3;
        q3 = {1'b0, f_div3(x)} * 7'd3;
        return 2'(x - q3);
    endfunction

    // floor(x/9) for x < 128: x*57 >> 9
    function automatic logic [3:0] f_div9(input logic [6:0] x);
        logic [12:0] p;
        p = {6'd0, x} * 13'd57;
        return p[12:9];
    endfunction

    function automatic logic [3:0] f_mod9(input logic [6:0] x);
        logic [6:0] q9;
        q9 = {3'd0, f_div9(x)} * 7'd9;
        return 4'(x - q9);
    endfunction

endpackage

### hw/rtl/pafd_decode.sv
// Decoder state (mode, phase, accumulator, lead digits) and the single-pass
// next-state and result logic for one character. Depends on pafd_pkg.
`timescale 1ns / 1ps

module pafd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_char,
    output pafd_pkg::t_bundle   o_bundle
);

    pafd_pkg::t_mode                          r_mode, n_mode;
    pafd_pkg::t_phase                         r_phase, n_phase;
    logic [pafd_pkg::ValueWidth-1:0]          r_acc, n_acc;
    logic [6:0]                               r_lead, n_lead;
    logic [1:0]                               r_fcnt, n_fcnt;

    logic                                     is_space;
    logic                                     is_cont;
    logic                                     is_fin;
    logic                                     is_let;
    logic [6:0]                               letter;
    logic [5:0]                               digit;
    logic [pafd_pkg::ValueWidth-1:0]          acc_base;
    logic [36:0]                              mac_full;
    logic [pafd_pkg::ValueWidth-1:0]          mac_sat;
    logic [7:0]                               lead_off;
    logic [7:0]                               follow_val;
    logic [3:0]                               n_div9;

    always_comb begin
        is_space = (i_char == pafd_pkg::ChSpace) ||
                   (i_char >= pafd_pkg::ChTab && i_char <= pafd_pkg::ChCr);
        is_cont  = (i_char >= pafd_pkg::ChBang) && (i_char <= pafd_pkg::ChContHi);
        is_fin   = (i_char >= pafd_pkg::ChFinLo) && (i_char <= pafd_pkg::ChLetHi);
        is_let   = is_cont || is_fin;
        letter   = 7'(i_char - pafd_pkg::ChBang);
        digit    = is_cont ? 6'(i_char - pafd_pkg::ChBang)
                           : 6'(i_char - pafd_pkg::ChFinLo);

        // a fresh integer starts from zero
        acc_base = (r_phase == pafd_pkg::PH_IDLE) ? '0 : r_acc;
        mac_full = {6'd0, acc_base} * 37'd42 + {31'd0, digit};
        mac_sat  = (mac_full > {6'd0, pafd_pkg::ValueMax}) ? pafd_pkg::ValueMax
                                                           : mac_full[30:0];

        case (pafd_pkg::f_mod3(r_lead))
            2'd1:    lead_off = pafd_pkg::FollowerStep;
            2'd2:    lead_off = 8'(2 * pafd_pkg::FollowerStep);
            default: lead_off = 8'd0;
        endcase
        follow_val = {1'b0, letter} + lead_off;
        n_div9     = pafd_pkg::f_div9(letter);
    end

    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_lead   = r_lead;
        n_fcnt   = r_fcnt;
        o_bundle = '0;

        if (!is_space) begin
            if (r_phase == pafd_pkg::PH_INT || r_phase == pafd_pkg::PH_RUN ||
                (r_phase == pafd_pkg::PH_IDLE && r_mode == pafd_pkg::MODE_U &&
                 is_let)) begin
                // base-42 integer digit
                if (is_cont) begin
                    n_acc = mac_sat;
                    if (r_phase == pafd_pkg::PH_IDLE) begin
                        n_phase = pafd_pkg::PH_INT;
                    end
                end else if (is_fin) begin
                    o_bundle.cnt      = 3'd1;
                    o_bundle.kind[0]  = (r_phase == pafd_pkg::PH_RUN) ?
                                        pafd_pkg::KIND_RUN : pafd_pkg::KIND_VALUE;
                    o_bundle.value[0] = mac_sat;
                    n_phase           = pafd_pkg::PH_IDLE;
                    n_acc             = '0;
                end else begin
                    o_bundle.cnt     = 3'd1;
                    o_bundle.kind[0] = pafd_pkg::KIND_BAD_INT;
                    n_mode  = pafd_pkg::MODE_U;
                    n_phase = pafd_pkg::PH_IDLE;
                    n_acc   = '0;
                    n_lead  = '0;
                    n_fcnt  = '0;
                end
            end else if (r_phase == pafd_pkg::PH_FOLLOW) begin
                o_bundle.cnt = 3'd1;
                if (is_let) begin
                    o_bundle.kind[0]  = pafd_pkg::KIND_VALUE;
                    o_bundle.value[0] = {23'd0, follow_val};
                    n_lead            = {1'b0, pafd_pkg::f_div3(r_lead)};
                    if (r_fcnt == 2'd3) begin
                        n_phase = pafd_pkg::PH_IDLE;
                        n_fcnt  = '0;
                        n_lead  = '0;
                    end else begin
                        n_fcnt = r_fcnt + 2'd1;
                    end
                end else begin
                    o_bundle.kind[0] = pafd_pkg::KIND_BAD_LET;
                    n_mode  = pafd_pkg::MODE_U;
                    n_phase = pafd_pkg::PH_IDLE;
                    n_acc   = '0;
                    n_lead  = '0;
                    n_fcnt  = '0;
                end
            end else if (i_char == pafd_pkg::ChEnd) begin
                o_bundle.cnt     = 3'd1;
                o_bundle.kind[0] = pafd_pkg::KIND_END;
                n_mode           = pafd_pkg::MODE_U;
            end else if (i_char == pafd_pkg::ChZero) begin
                n_phase = pafd_pkg::PH_RUN;
                n_acc   = '0;
            end else if (i_char >= pafd_pkg::ChModeU && i_char <= pafd_pkg::ChModeY) begin
                case (3'(i_char - pafd_pkg::ChModeU))
                    3'd1:    n_mode = pafd_pkg::MODE_V;
                    3'd2:    n_mode = pafd_pkg::MODE_W;
                    3'd3:    n_mode = pafd_pkg::MODE_X;
                    3'd4:    n_mode = pafd_pkg::MODE_Y;
                    default: n_mode = pafd_pkg::MODE_U;
                endcase
            end else if (!is_let) begin
                o_bundle.cnt     = 3'd1;
                o_bundle.kind[0] = pafd_pkg::KIND_BAD_LET;
                n_mode  = pafd_pkg::MODE_U;
                n_phase = pafd_pkg::PH_IDLE;
                n_acc   = '0;
                n_lead  = '0;
                n_fcnt  = '0;
            end else begin
                // letter while idle in modes v..y (mode u handled above)
                case (r_mode)
                    pafd_pkg::MODE_V: begin
                        n_lead  = letter;
                        n_fcnt  = '0;
                        n_phase = pafd_pkg::PH_FOLLOW;
                    end
                    pafd_pkg::MODE_W: begin
                        o_bundle.cnt      = 3'd1;
                        o_bundle.value[0] = {24'd0, letter};
                    end
                    pafd_pkg::MODE_X: begin
                        o_bundle.cnt      = 3'd2;
                        o_bundle.value[0] = {27'd0, n_div9};
                        o_bundle.value[1] = {27'd0, pafd_pkg::f_mod9(letter)};
                    end
                    pafd_pkg::MODE_Y: begin
                        o_bundle.cnt      = 3'd4;
                        o_bundle.value[0] = {25'd0, pafd_pkg::f_div3({3'd0, n_div9})};
                        o_bundle.value[1] = {29'd0, pafd_pkg::f_mod3({3'd0, n_div9})};
                        o_bundle.value[2] =
                            {29'd0, pafd_pkg::f_mod3({1'b0, pafd_pkg::f_div3(letter)})};
                        o_bundle.value[3] = {29'd0, pafd_pkg::f_mod3(letter)};
                    end
                    default: begin
                        n_mode = pafd_pkg::MODE_U;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pafd_pkg::MODE_U;
            r_phase <= pafd_pkg::PH_IDLE;
            r_acc   <= '0;
            r_lead  <= '0;
            r_fcnt  <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_lead  <= n_lead;
            r_fcnt  <= n_fcnt;
        end
    end

endmodule

### hw/rtl/pafd_serializer.sv
// Result register: holds the results of one character and hands them out
// one item at a time. Depends on pafd_pkg.
`timescale 1ns / 1ps

module pafd_serializer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  pafd_pkg::t_bundle                 i_bundle,
    output logic                              o_free,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_kind,
    output logic [pafd_pkg::ValueWidth-1:0]   o_value,
    output logic                              o_last
);

    logic                r_vld;
    logic [1:0]          r_pos;
    pafd_pkg::t_bundle   r_bundle;
    logic                take;
    logic                is_last;

    assign is_last = ({1'b0, r_pos} + 3'd1) == r_bundle.cnt;
    assign take    = r_vld && !i_stall;
    assign o_free  = !r_vld || (take && is_last);

    assign o_valid = r_vld;
    assign o_kind  = r_bundle.kind[r_pos];
    assign o_value = r_bundle.value[r_pos];
    assign o_last  = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_pos <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_pos <= '0;
        end else if (take) begin
            // advance, drop the bundle after its last item
            if (is_last) begin
                r_vld <= 1'b0;
            end
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

### hw/rtl/packed_ascii_field_decoder_unit.sv
// Top level of the packed ASCII field decoder: input register, decoder and
// result serializer. Depends on pafd_pkg, pafd_decode and pafd_serializer.
`timescale 1ns / 1ps

// One character enters per item and produces zero to four result items
// (kind, value, last), with last set on the final result of a character.
// The input side takes one character per cycle as long as each character
// yields at most one result and the output is not stalled; a character that
// yields more results (mode x gives two, mode y four) holds the output until
// its last result is taken, and the input stalls behind it. Whitespace and
// mode letters give no results. From input acceptance, a character passes
// through the input register, then the decoder into the result register.
// All decoding, including the saturating base-42 multiply-add, is done in a
// single pass between those two registers.
module packed_ascii_field_decoder_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_in_char,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_kind,
    output logic [pafd_pkg::ValueWidth-1:0]   o_value,
    output logic                              o_last
);

    logic                r_in_vld;
    logic [7:0]          r_char;
    logic                accept;
    logic                fire;
    logic                res_free;
    pafd_pkg::t_bundle   bundle;

    // decode the held character once the result register can take its results
    assign fire    = r_in_vld && res_free;
    assign o_stall = r_in_vld && !res_free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // hold the character until it is decoded
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_in_char;
        end
    end

    pafd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_char   (r_char),
        .o_bundle (bundle)
    );

    // characters with no results update state only
    pafd_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && (bundle.cnt != 3'd0)),
        .i_bundle (bundle),
        .o_free   (res_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_kind   (o_kind),
        .o_value  (o_value),
        .o_last   (o_last)
    );

endmodule
